FILE: sv/ebp_pkg.sv
// Package for the ego occupancy point binning block.
// Holds default parameters, register indexes, reset values and shared types.
// No dependencies.
package ebp_pkg;

	localparam int GRID_SIZE_DEF = 201;
	localparam int ORIGIN_X_CELLS_DEF = -100;
	localparam int ORIGIN_Y_CELLS_DEF = 100;
	localparam int COORD_FRAC_BITS_DEF = 10;

	localparam int IDX_W = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 40;
	localparam int WORD_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_POS_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_POS_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_COSINE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_SINE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_MIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_MAX = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_METRE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQUARED = 3'd7;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic signed [15:0] YAW_COSINE_RST = 16'sd16384;
	localparam logic signed [23:0] HEIGHT_MIN_RST = -24'sd8388608;
	localparam logic signed [23:0] HEIGHT_MAX_RST = 24'sd8388607;
	localparam logic [15:0] CELLS_PER_METRE_RST = 16'd5120;
	localparam logic [39:0] RADIUS_SQUARED_RST = 40'd104857600;

	typedef struct packed {
		logic signed [23:0] robot_pos_x;
		logic signed [23:0] robot_pos_y;
		logic signed [15:0] yaw_cosine;
		logic signed [15:0] yaw_sine;
		logic signed [23:0] height_min;
		logic signed [23:0] height_max;
		logic [15:0] cells_per_metre;
		logic [39:0] radius_squared;
	} ebp_cfg_t;

	typedef struct packed {
		logic done;
		logic hit;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} ebp_xf_res_t;

endpackage

FILE: sv/ebp_grid_ram.sv
// Single-port-read, single-port-write synchronous RAM holding the grid words.
// Read data is registered. Depends on nothing.
module ebp_grid_ram #(
	parameter int DEPTH = 804,
	parameter int DW = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/ebp_xform.sv
// Six-stage point transform: height gate, robot offset, yaw rotation,
// radius test and conversion to a grid cell. Depends on ebp_pkg.
module ebp_xform import ebp_pkg::*; #(
	parameter int GRID_SIZE = GRID_SIZE_DEF,
	parameter int ORIGIN_X_CELLS = ORIGIN_X_CELLS_DEF,
	parameter int ORIGIN_Y_CELLS = ORIGIN_Y_CELLS_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [23:0] point_x,
	input  logic signed [23:0] point_y,
	input  logic signed [23:0] point_z,
	input  ebp_cfg_t           cfg,
	output ebp_xf_res_t        res
);

	localparam int S = COORD_FRAC_BITS + 8;
	localparam int VW = 48;
	localparam logic signed [VW-1:0] OX_SC =
		VW'(longint'(ORIGIN_X_CELLS) * (longint'(1) << S));
	localparam logic signed [VW-1:0] OY_SC =
		VW'(longint'(ORIGIN_Y_CELLS) * (longint'(1) << S));

	logic [6:1] v_q;
	logic [5:1] keep_q;

	logic signed [24:0] dx_s1, dy_s1;
	logic signed [40:0] pcx_s2, psy_s2, pcy_s2, psx_s2;
	logic signed [27:0] ex_s3, ey_s3;
	logic signed [55:0] sqx_s4, sqy_s4;
	logic signed [44:0] mx_s4, my_s4;
	logic signed [VW-1:0] colv_s5, rowv_s5;
	logic hit_s6;
	logic [IDX_W-1:0] row_s6, col_s6;

	logic signed [41:0] sum_x, sum_y;
	logic [56:0] r2;
	logic signed [VW-1:0] col_fl, row_fl;
	logic [VW-1:0] col_t, row_t;
	logic col_ok, row_ok;

	always_comb begin
		sum_x = 42'(pcx_s2) + 42'(psy_s2);
		sum_y = 42'(pcy_s2) - 42'(psx_s2);
		r2 = 57'($unsigned(sqx_s4)) + 57'($unsigned(sqy_s4));
		col_fl = colv_s5 >>> S;
		row_fl = rowv_s5 >>> S;
		col_t = $unsigned(col_fl) + VW'(colv_s5[VW-1] && (colv_s5[S-1:0] != '0));
		row_t = $unsigned(row_fl) + VW'(rowv_s5[VW-1] && (rowv_s5[S-1:0] != '0));
		col_ok = !col_t[VW-1] && (col_t < VW'(GRID_SIZE));
		row_ok = !row_t[VW-1] && (row_t < VW'(GRID_SIZE));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[5:1], start};
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= 25'(point_x) - 25'(cfg.robot_pos_x);
		dy_s1 <= 25'(point_y) - 25'(cfg.robot_pos_y);
		keep_q[1] <= (point_z >= cfg.height_min) && (point_z <= cfg.height_max);

		pcx_s2 <= $signed(cfg.yaw_cosine) * dx_s1;
		psy_s2 <= $signed(cfg.yaw_sine) * dy_s1;
		pcy_s2 <= $signed(cfg.yaw_cosine) * dy_s1;
		psx_s2 <= $signed(cfg.yaw_sine) * dx_s1;
		keep_q[2] <= keep_q[1];

		ex_s3 <= 28'(sum_x >>> 14);
		ey_s3 <= 28'(sum_y >>> 14);
		keep_q[3] <= keep_q[2];

		sqx_s4 <= ex_s3 * ex_s3;
		sqy_s4 <= ey_s3 * ey_s3;
		mx_s4 <= ex_s3 * $signed({1'b0, cfg.cells_per_metre});
		my_s4 <= ey_s3 * $signed({1'b0, cfg.cells_per_metre});
		keep_q[4] <= keep_q[3];

		colv_s5 <= VW'(mx_s4) - OX_SC;
		rowv_s5 <= OY_SC - VW'(my_s4);
		keep_q[5] <= keep_q[4] && (r2 <= 57'(cfg.radius_squared));

		hit_s6 <= keep_q[5] && col_ok && row_ok;
		col_s6 <= IDX_W'(col_t);
		row_s6 <= IDX_W'(row_t);
	end

	always_comb begin
		res.done = v_q[6];
		res.hit = hit_s6;
		res.row = row_s6;
		res.col = col_s6;
	end

endmodule

FILE: sv/ego_occupancy_point_binning.sv
// Channel   Handshake             Payload
// in        in_valid / in_ready   cmd, point_x, point_y, point_z, read_row, read_word
// out       out_valid / out_ready point_marked, cell_row, cell_col, cell_bits
// cfg       cfg_wr_en             cfg_index, cfg_data
// One transaction at a time: for an insert the six-stage transform feeds one
// read-modify-write of a grid word through the RAM's single read port.
// After reset all GRID_SIZE * ceil(GRID_SIZE / 64) grid words (804 by default) are swept
// to zero while in_ready stays low. A stalled output register holds the write-back.
// Top level: sequencer, configuration registers, clearing sweep and output register.
// Depends on ebp_pkg, ebp_xform and ebp_grid_ram.
module ego_occupancy_point_binning import ebp_pkg::*; #(
	parameter int GRID_SIZE = GRID_SIZE_DEF,
	parameter int ORIGIN_X_CELLS = ORIGIN_X_CELLS_DEF,
	parameter int ORIGIN_Y_CELLS = ORIGIN_Y_CELLS_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cmd,
	input  logic signed [23:0]    point_x,
	input  logic signed [23:0]    point_y,
	input  logic signed [23:0]    point_z,
	input  logic [7:0]            read_row,
	input  logic [1:0]            read_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  point_marked,
	output logic [7:0]            cell_row,
	output logic [7:0]            cell_col,
	output logic [WORD_W-1:0]     cell_bits
);

	localparam int WPR = (GRID_SIZE + 63) / 64;
	localparam int GW = GRID_SIZE * WPR;
	localparam int AW = $clog2(GW);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_XFORM = 2'd1;
	localparam logic [1:0] ST_RD = 2'd2;
	localparam logic [1:0] ST_WB = 2'd3;

	ebp_cfg_t cfg_q;
	ebp_xf_res_t xf_res;

	logic [1:0] state_q;
	logic clr_q;
	logic [AW-1:0] clr_addr_q;
	logic op_q;
	logic hit_q;
	logic [AW-1:0] addr_q;
	logic [5:0] bit_q;
	logic [IDX_W-1:0] row_q, col_q;

	logic out_valid_q;
	logic marked_q;
	logic [7:0] row_out_q, col_out_q;
	logic [WORD_W-1:0] bits_out_q;

	logic accept, xf_start, wb_go, rd_ok;
	logic mem_rd_en, mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	logic [WORD_W-1:0] mem_rd_data, mem_wr_data;

	assign in_ready = (state_q == ST_IDLE) && !clr_q;
	assign accept = in_valid && in_ready;
	assign xf_start = accept && (cmd == CMD_INSERT);
	assign wb_go = !out_valid_q || out_ready;
	assign rd_ok = (int'(read_row) < GRID_SIZE) && (int'(read_word) < WPR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.robot_pos_x <= '0;
			cfg_q.robot_pos_y <= '0;
			cfg_q.yaw_cosine <= YAW_COSINE_RST;
			cfg_q.yaw_sine <= '0;
			cfg_q.height_min <= HEIGHT_MIN_RST;
			cfg_q.height_max <= HEIGHT_MAX_RST;
			cfg_q.cells_per_metre <= CELLS_PER_METRE_RST;
			cfg_q.radius_squared <= RADIUS_SQUARED_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ROBOT_POS_X: cfg_q.robot_pos_x <= cfg_data[23:0];
				CFG_ROBOT_POS_Y: cfg_q.robot_pos_y <= cfg_data[23:0];
				CFG_YAW_COSINE: cfg_q.yaw_cosine <= cfg_data[15:0];
				CFG_YAW_SINE: cfg_q.yaw_sine <= cfg_data[15:0];
				CFG_HEIGHT_MIN: cfg_q.height_min <= cfg_data[23:0];
				CFG_HEIGHT_MAX: cfg_q.height_max <= cfg_data[23:0];
				CFG_CELLS_PER_METRE: cfg_q.cells_per_metre <= cfg_data[15:0];
				CFG_RADIUS_SQUARED: cfg_q.radius_squared <= cfg_data[39:0];
				default: ;
			endcase
		end
	end

	ebp_xform #(
		.GRID_SIZE(GRID_SIZE),
		.ORIGIN_X_CELLS(ORIGIN_X_CELLS),
		.ORIGIN_Y_CELLS(ORIGIN_Y_CELLS),
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_xform (
		.clk(clk),
		.arst_n(arst_n),
		.start(xf_start),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.cfg(cfg_q),
		.res(xf_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clr_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (clr_q) begin
				if (clr_addr_q == AW'(GW - 1)) begin
					clr_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (cmd == CMD_READ) ? ST_RD : ST_XFORM;
					end
				end
				ST_XFORM: begin
					if (xf_res.done) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_WB;
				ST_WB: begin
					if (wb_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= cmd;
			hit_q <= rd_ok;
			addr_q <= AW'(read_row) * AW'(WPR) + AW'(read_word);
			row_q <= '0;
			col_q <= '0;
			bit_q <= '0;
		end else if (state_q == ST_XFORM && xf_res.done) begin
			hit_q <= xf_res.hit;
			addr_q <= AW'(xf_res.row) * AW'(WPR) + AW'(xf_res.col >> 6);
			row_q <= xf_res.row;
			col_q <= xf_res.col;
			bit_q <= 6'(xf_res.col);
		end
	end

	assign mem_rd_en = (state_q == ST_RD);
	assign mem_wr_en = clr_q || ((state_q == ST_WB) && wb_go && hit_q);
	assign mem_wr_addr = clr_q ? clr_addr_q : addr_q;
	assign mem_wr_data = (clr_q || op_q == CMD_READ) ? '0
		: (mem_rd_data | (WORD_W'(1) << bit_q));

	ebp_grid_ram #(
		.DEPTH(GW),
		.DW(WORD_W)
	) u_grid_ram (
		.clk(clk),
		.rd_en(mem_rd_en),
		.rd_addr(addr_q),
		.rd_data(mem_rd_data),
		.wr_en(mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_WB && wb_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WB && wb_go) begin
			marked_q <= (op_q == CMD_INSERT) && hit_q;
			row_out_q <= ((op_q == CMD_INSERT) && hit_q) ? 8'(row_q) : '0;
			col_out_q <= ((op_q == CMD_INSERT) && hit_q) ? 8'(col_q) : '0;
			bits_out_q <= ((op_q == CMD_READ) && hit_q) ? mem_rd_data : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign point_marked = marked_q;
	assign cell_row = row_out_q;
	assign cell_col = col_out_q;
	assign cell_bits = bits_out_q;

endmodule

FILE: sv/ebp_port_checker.sv
// Port-level checks for ego_occupancy_point_binning and the bind that attaches them.
// Depends on ebp_pkg and the top level's ports.
module ebp_port_checker import ebp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic              point_marked,
	input logic [7:0]        cell_row,
	input logic [7:0]        cell_col,
	input logic [WORD_W-1:0] cell_bits
);

	// A stalled result must hold until the transaction completes.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cell_bits) && $stable(point_marked))
		else $error("output changed while stalled");

	// Only one transaction is in flight at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a transaction is in flight");

	// An insert result never carries grid bits.
	a_insert_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && point_marked |-> cell_bits == '0)
		else $error("marked point with nonzero cell bits");

	// Without a marked cell the cell coordinates are zero.
	a_unmarked_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_marked |-> cell_row == '0 && cell_col == '0)
		else $error("unmarked result with nonzero cell coordinates");

endmodule

bind ego_occupancy_point_binning ebp_port_checker u_ebp_port_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.point_marked(point_marked),
	.cell_row(cell_row),
	.cell_col(cell_col),
	.cell_bits(cell_bits)
);

FILE: bench/tb.sv
// Self-checking testbench for ego_occupancy_point_binning: random and directed point and
// read commands, each result checked against a bit-exact model of the binning and grid.
// Depends on ebp_pkg and the block's RTL.
module tb import ebp_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORDS_PER_ROW = (GRID_SIZE_DEF + 63) / 64;
	localparam int GRID_WORDS = GRID_SIZE_DEF * WORDS_PER_ROW;
	localparam int CELL_SHIFT = COORD_FRAC_BITS_DEF + 8;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic cmd;
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
		logic signed [23:0] point_z;
		logic [7:0] read_row;
		logic [1:0] read_word;
	} grid_cmd_t;

	typedef struct packed {
		logic marked;
		logic [7:0] row;
		logic [7:0] col;
		logic [63:0] bits;
	} cell_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = CMD_INSERT;
	logic signed [23:0] point_x = '0;
	logic signed [23:0] point_y = '0;
	logic signed [23:0] point_z = '0;
	logic [7:0] read_row = '0;
	logic [1:0] read_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic point_marked;
	logic [7:0] cell_row;
	logic [7:0] cell_col;
	logic [WORD_W-1:0] cell_bits;

	ebp_cfg_t regs;
	logic [63:0] grid_model [GRID_WORDS];
	grid_cmd_t cmd_queue [$];
	cell_result_t expected_cells [$];
	int unsigned marked_words [$];
	grid_cmd_t cmd_on_bus;
	cell_result_t want;
	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	int mismatches = 0;
	int stall_cycles = 0;

	ego_occupancy_point_binning uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.read_row(read_row),
		.read_word(read_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.point_marked(point_marked),
		.cell_row(cell_row),
		.cell_col(cell_col),
		.cell_bits(cell_bits)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic ebp_cfg_t reset_regs();
		ebp_cfg_t c;
		c.robot_pos_x = '0;
		c.robot_pos_y = '0;
		c.yaw_cosine = YAW_COSINE_RST;
		c.yaw_sine = '0;
		c.height_min = HEIGHT_MIN_RST;
		c.height_max = HEIGHT_MAX_RST;
		c.cells_per_metre = CELLS_PER_METRE_RST;
		c.radius_squared = RADIUS_SQUARED_RST;
		return c;
	endfunction

	function automatic longint toward_zero(input longint v, input int s);
		if (v >= 0)
			return v >>> s;
		return -((-v) >>> s);
	endfunction

	function automatic logic bin_point(input logic signed [23:0] px, input logic signed [23:0] py,
			input logic signed [23:0] pz, output logic [7:0] row8, output logic [7:0] col8,
			output int unsigned word_idx, output int unsigned bit_idx);
		longint dx, dy, ex, ey, cs, sn, cpm, colv, rowv;
		row8 = '0;
		col8 = '0;
		word_idx = 0;
		bit_idx = 0;
		if (pz < $signed(regs.height_min) || pz > $signed(regs.height_max))
			return 1'b0;
		dx = longint'(px) - longint'($signed(regs.robot_pos_x));
		dy = longint'(py) - longint'($signed(regs.robot_pos_y));
		cs = longint'($signed(regs.yaw_cosine));
		sn = longint'($signed(regs.yaw_sine));
		ex = (cs * dx + sn * dy) >>> 14;
		ey = (cs * dy - sn * dx) >>> 14;
		if (ex * ex + ey * ey > longint'(regs.radius_squared))
			return 1'b0;
		cpm = longint'(regs.cells_per_metre);
		colv = toward_zero(ex * cpm - longint'(ORIGIN_X_CELLS_DEF) * (longint'(1) <<< CELL_SHIFT),
			CELL_SHIFT);
		rowv = toward_zero(longint'(ORIGIN_Y_CELLS_DEF) * (longint'(1) <<< CELL_SHIFT) - ey * cpm,
			CELL_SHIFT);
		if (colv < 0 || colv >= GRID_SIZE_DEF || rowv < 0 || rowv >= GRID_SIZE_DEF)
			return 1'b0;
		row8 = rowv[7:0];
		col8 = colv[7:0];
		word_idx = 32'(rowv * WORDS_PER_ROW + colv / 64);
		bit_idx = 32'(colv % 64);
		return 1'b1;
	endfunction

	function automatic cell_result_t apply_command(input grid_cmd_t c);
		cell_result_t r;
		int unsigned widx, bidx;
		r = '0;
		if (c.cmd == CMD_READ) begin
			if (c.read_row < GRID_SIZE_DEF && c.read_word < WORDS_PER_ROW) begin
				widx = c.read_row * WORDS_PER_ROW + c.read_word;
				r.bits = grid_model[widx];
				grid_model[widx] = '0;
			end
		end else if (bin_point(c.point_x, c.point_y, c.point_z, r.row, r.col, widx, bidx)) begin
			grid_model[widx] = grid_model[widx] | (64'd1 << bidx);
			r.marked = 1'b1;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	task automatic program_regs(input ebp_cfg_t c);
		write_reg(CFG_ROBOT_POS_X, {{16{c.robot_pos_x[23]}}, c.robot_pos_x});
		write_reg(CFG_ROBOT_POS_Y, {{16{c.robot_pos_y[23]}}, c.robot_pos_y});
		write_reg(CFG_YAW_COSINE, {{24{c.yaw_cosine[15]}}, c.yaw_cosine});
		write_reg(CFG_YAW_SINE, {{24{c.yaw_sine[15]}}, c.yaw_sine});
		write_reg(CFG_HEIGHT_MIN, {{16{c.height_min[23]}}, c.height_min});
		write_reg(CFG_HEIGHT_MAX, {{16{c.height_max[23]}}, c.height_max});
		write_reg(CFG_CELLS_PER_METRE, {24'd0, c.cells_per_metre});
		write_reg(CFG_RADIUS_SQUARED, c.radius_squared);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		regs = c;
	endtask

	function automatic ebp_cfg_t random_regs();
		ebp_cfg_t c;
		int lo;
		case ($urandom_range(9))
			0: begin
				c.robot_pos_x = 24'sh800000;
				c.robot_pos_y = 24'sh7FFFFF;
			end
			1: begin
				c.robot_pos_x = 24'sh7FFFFF;
				c.robot_pos_y = 24'sh800000;
			end
			2: begin
				c.robot_pos_x = 24'($urandom());
				c.robot_pos_y = 24'($urandom());
			end
			default: begin
				c.robot_pos_x = 24'(int'($urandom_range(0, 200000)) - 100000);
				c.robot_pos_y = 24'(int'($urandom_range(0, 200000)) - 100000);
			end
		endcase
		case ($urandom_range(6))
			0: begin
				c.yaw_cosine = 16'sd16384;
				c.yaw_sine = 16'sd0;
			end
			1: begin
				c.yaw_cosine = -16'sd16384;
				c.yaw_sine = 16'sd0;
			end
			2: begin
				c.yaw_cosine = 16'sd0;
				c.yaw_sine = 16'sd16384;
			end
			3: begin
				c.yaw_cosine = 16'sd0;
				c.yaw_sine = -16'sd16384;
			end
			default: begin
				c.yaw_cosine = 16'(int'($urandom_range(0, 32768)) - 16384);
				c.yaw_sine = 16'(int'($urandom_range(0, 32768)) - 16384);
			end
		endcase
		lo = int'($urandom_range(0, 8192)) - 4096;
		case ($urandom_range(7))
			0: begin
				c.height_min = 24'(lo + 100);
				c.height_max = 24'(lo);
			end
			1: begin
				c.height_min = 24'sh800000;
				c.height_max = 24'sh7FFFFF;
			end
			2: begin
				c.height_min = 24'(lo);
				c.height_max = 24'(lo);
			end
			default: begin
				c.height_min = 24'(lo);
				c.height_max = 24'(lo + int'($urandom_range(0, 8192)));
			end
		endcase
		case ($urandom_range(9))
			0: c.cells_per_metre = 16'hFFFF;
			1: c.cells_per_metre = 16'd1;
			2: c.cells_per_metre = 16'($urandom());
			default: c.cells_per_metre = 16'($urandom_range(1024, 8192));
		endcase
		case ($urandom_range(7))
			0: c.radius_squared = '0;
			1: c.radius_squared = '1;
			default: c.radius_squared = 40'({$urandom(), $urandom()} >> $urandom_range(24, 46));
		endcase
		return c;
	endfunction

	task automatic add_insert(input int x, input int y, input int z);
		grid_cmd_t c;
		c = '0;
		c.cmd = CMD_INSERT;
		c.point_x = 24'(x);
		c.point_y = 24'(y);
		c.point_z = 24'(z);
		cmd_queue = {cmd_queue, c};
	endtask

	task automatic add_read(input int row, input int word);
		grid_cmd_t c;
		c = '0;
		c.cmd = CMD_READ;
		c.read_row = 8'(row);
		c.read_word = 2'(word);
		cmd_queue = {cmd_queue, c};
	endtask

	task automatic add_random_item();
		grid_cmd_t c;
		longint span, hmin, hmax;
		logic [7:0] r8, c8;
		int unsigned widx, bidx, pick;
		c = '0;
		pick = $urandom_range(99);
		if (pick < 30) begin
			c.cmd = CMD_READ;
			if (marked_words.size() != 0 && $urandom_range(9) < 7) begin
				widx = marked_words[$urandom_range(marked_words.size() - 1)];
				c.read_row = 8'(widx / WORDS_PER_ROW);
				c.read_word = 2'(widx % WORDS_PER_ROW);
			end else begin
				c.read_row = 8'($urandom());
				c.read_word = 2'($urandom());
			end
		end else begin
			c.cmd = CMD_INSERT;
			if (pick < 45) begin
				c.point_x = 24'($urandom());
				c.point_y = 24'($urandom());
				c.point_z = 24'($urandom());
			end else begin
				if (regs.cells_per_metre == 0)
					span = 4096;
				else
					span = 120 * 262144 / longint'(regs.cells_per_metre);
				if (span > 4000000)
					span = 4000000;
				c.point_x = 24'(longint'($signed(regs.robot_pos_x)) - span
					+ longint'($urandom_range(0, 32'(2 * span))));
				c.point_y = 24'(longint'($signed(regs.robot_pos_y)) - span
					+ longint'($urandom_range(0, 32'(2 * span))));
				hmin = longint'($signed(regs.height_min));
				hmax = longint'($signed(regs.height_max));
				if (hmin <= hmax && $urandom_range(9) != 0)
					c.point_z = 24'(hmin + longint'($urandom()) % (hmax - hmin + 1));
				else
					c.point_z = 24'($urandom());
			end
			if (bin_point(c.point_x, c.point_y, c.point_z, r8, c8, widx, bidx)) begin
				marked_words = {marked_words, widx};
				if (marked_words.size() > 32)
					void'(marked_words.pop_front());
			end
		end
		cmd_queue = {cmd_queue, c};
	endtask

	task automatic drain();
		while (cmd_queue.size() != 0 || in_valid || expected_cells.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_cells = {expected_cells, apply_command(cmd_on_bus)};
			if (!in_valid || in_ready) begin
				if (cmd_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					cmd_on_bus = cmd_queue.pop_front();
					in_valid <= 1'b1;
					cmd <= cmd_on_bus.cmd;
					point_x <= cmd_on_bus.point_x;
					point_y <= cmd_on_bus.point_y;
					point_z <= cmd_on_bus.point_z;
					read_row <= cmd_on_bus.read_row;
					read_word <= cmd_on_bus.read_word;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_gap_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_cells.size() == 0) begin
				report_mismatch("result transaction with nothing expected");
			end else begin
				want = expected_cells.pop_front();
				if (point_marked !== want.marked)
					report_mismatch($sformatf("point_marked %b, expected %b",
						point_marked, want.marked));
				if (cell_row !== want.row)
					report_mismatch($sformatf("cell_row %0d, expected %0d", cell_row, want.row));
				if (cell_col !== want.col)
					report_mismatch($sformatf("cell_col %0d, expected %0d", cell_col, want.col));
				if (cell_bits !== want.bits)
					report_mismatch($sformatf("cell_bits %h, expected %h", cell_bits, want.bits));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		ebp_cfg_t c;
		regs = reset_regs();
		foreach (grid_model[i])
			grid_model[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_gap_pct = 37;
		recv_gap_pct = 52;
		@(negedge clk);
		add_insert(0, 0, 0);
		add_insert(5119, 0, 8388607);
		add_insert(-5120, 5120, -8388608);
		add_insert(8388607, 8388607, 0);
		add_insert(-8388608, -8388608, 0);
		add_insert(6000, 0, 0);
		add_read(100, 1);
		add_read(100, 1);
		add_read(200, 3);
		add_read(255, 3);
		add_read(201, 0);
		add_read(0, 0);
		add_read(100, 3);
		drain();

		c = reset_regs();
		c.height_min = 24'sd100;
		c.height_max = -24'sd100;
		c.robot_pos_x = 24'sh7FFFFF;
		c.robot_pos_y = 24'sh800000;
		c.yaw_cosine = -16'sd16384;
		c.yaw_sine = 16'sd16384;
		program_regs(c);
		@(negedge clk);
		add_insert(8388607, -8388608, 0);
		add_insert(0, 0, 0);
		drain();

		c = reset_regs();
		c.cells_per_metre = '0;
		c.radius_squared = '1;
		c.robot_pos_x = 24'sh800000;
		c.robot_pos_y = 24'sh7FFFFF;
		c.yaw_sine = -16'sd16384;
		c.height_min = -24'sd5;
		c.height_max = 24'sd5;
		program_regs(c);
		@(negedge clk);
		add_insert(-8388608, 8388607, 5);
		add_insert(-8388000, 8388000, -5);
		add_insert(0, 0, 0);
		add_insert(-8388608, 8388607, 6);
		add_read(100, 1);
		drain();

		c = reset_regs();
		c.radius_squared = '0;
		c.cells_per_metre = 16'hFFFF;
		program_regs(c);
		@(negedge clk);
		add_insert(0, 0, 0);
		add_insert(1, 0, 0);
		add_insert(0, -1, 0);
		add_read(100, 1);
		drain();

		for (int ph = 0; ph < 13; ph++) begin
			if (ph < 5) begin
				send_gap_pct = 37;
				recv_gap_pct = 52;
			end else if (ph < 10) begin
				send_gap_pct = 52;
				recv_gap_pct = 37;
			end else begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end
			program_regs(random_regs());
			@(negedge clk);
			repeat (100) add_random_item();
			drain();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
